### rtl/vrm_pkg.sv
// ---------------------------------------------------------------------------
// vrm_pkg
// Shared types and constants for the voxel ray march core.
// ---------------------------------------------------------------------------
`default_nettype none

package vrm_pkg;

	// default grid geometry and id width
	localparam int GRID_WIDTH_DEF     = 32;
	localparam int GRID_HEIGHT_DEF    = 32;
	localparam int GRID_DEPTH_DEF     = 32;
	localparam int CELL_SIZE_LOG2_DEF = 2;
	localparam int ID_BITS_DEF        = 16;

	// fixed field widths
	localparam int COORD_W = 5;   // cell coordinate ports
	localparam int ID_W    = 16;  // id ports
	localparam int VEC_W   = 16;  // Q8.8 origin and direction
	localparam int STEP_W  = 8;   // step count

	// march position: Q.9, wide enough for 2^16 plus 255 steps of 2^15
	localparam int FRAC_BITS = 9;
	localparam int POS_W     = 25;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_RAY   = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MARCH
	} state_t;

	// control towards the march datapath
	typedef struct packed {
		logic load;   // take a new ray
		logic step;   // advance one half step and probe the store
	} march_ctl_t;

	// status from the march datapath
	typedef struct packed {
		logic               steps_zero;  // no steps left to issue
		logic               probe_s1;    // last probe was inside the grid
		logic [COORD_W-1:0] cx_s1;
		logic [COORD_W-1:0] cy_s1;
		logic [COORD_W-1:0] cz_s1;
	} march_stat_t;

endpackage

`default_nettype wire

### rtl/vrm_store.sv
// ---------------------------------------------------------------------------
// vrm_store
// Voxel id memory: one write port, one registered read port, and a
// clearing sweep after reset that zeroes every entry.
// ---------------------------------------------------------------------------
`default_nettype none

module vrm_store #(
	parameter int ADDR_W  = 15,
	parameter int ID_BITS = vrm_pkg::ID_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire logic [ADDR_W-1:0]  wr_addr,
	input  wire logic [ID_BITS-1:0] wr_data,
	input  wire logic               rd_en,
	input  wire logic [ADDR_W-1:0]  rd_addr,
	output logic      [ID_BITS-1:0] rd_data,
	output logic                    clr_done
);

	localparam int DEPTH = 2 ** ADDR_W;

	logic [ID_BITS-1:0] mem [DEPTH];
	logic               clr_active_q;
	logic [ADDR_W-1:0]  clr_addr_q;
	logic               we;
	logic [ADDR_W-1:0]  waddr;
	logic [ID_BITS-1:0] wdata;

	// clearing sweep, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q)
				clr_active_q <= 1'b0;
		end
	end

	// sweep owns the write port while active
	always_comb begin
		if (clr_active_q) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else begin
			we    = wr_en;
			waddr = wr_addr;
			wdata = wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

	assign clr_done = !clr_active_q;

endmodule

`default_nettype wire

### rtl/vrm_march.sv
// ---------------------------------------------------------------------------
// vrm_march
// Ray position datapath: holds the Q.9 position, direction and steps left,
// advances one half step a cycle while step is set, and forms the cell address to probe.
// ---------------------------------------------------------------------------
`default_nettype none

module vrm_march #(
	parameter int GRID_WIDTH     = vrm_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT    = vrm_pkg::GRID_HEIGHT_DEF,
	parameter int GRID_DEPTH     = vrm_pkg::GRID_DEPTH_DEF,
	parameter int CELL_SIZE_LOG2 = vrm_pkg::CELL_SIZE_LOG2_DEF,
	parameter int XW             = $clog2(GRID_WIDTH),
	parameter int YW             = $clog2(GRID_HEIGHT),
	parameter int ZW             = $clog2(GRID_DEPTH)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire vrm_pkg::march_ctl_t               ctl,
	input  wire logic signed [vrm_pkg::VEC_W-1:0]  origin_x,
	input  wire logic signed [vrm_pkg::VEC_W-1:0]  origin_y,
	input  wire logic signed [vrm_pkg::VEC_W-1:0]  origin_z,
	input  wire logic signed [vrm_pkg::VEC_W-1:0]  dir_x,
	input  wire logic signed [vrm_pkg::VEC_W-1:0]  dir_y,
	input  wire logic signed [vrm_pkg::VEC_W-1:0]  dir_z,
	input  wire logic        [vrm_pkg::STEP_W-1:0] max_steps,
	output logic             [XW+YW+ZW-1:0]        rd_addr,
	output vrm_pkg::march_stat_t                   stat
);

	localparam int POS_W = vrm_pkg::POS_W;
	localparam int VEC_W = vrm_pkg::VEC_W;
	localparam int CW    = vrm_pkg::COORD_W;
	localparam int SHIFT = vrm_pkg::FRAC_BITS + CELL_SIZE_LOG2;

	localparam logic [POS_W-1:0] LIM_X = POS_W'(GRID_WIDTH);
	localparam logic [POS_W-1:0] LIM_Y = POS_W'(GRID_HEIGHT);
	localparam logic [POS_W-1:0] LIM_Z = POS_W'(GRID_DEPTH);

	logic signed [POS_W-1:0]          pos_q [3];
	logic signed [VEC_W-1:0]          dir_q [3];
	logic        [vrm_pkg::STEP_W-1:0] left_q;
	logic signed [POS_W-1:0]          org_ext [3];
	logic signed [POS_W-1:0]          nxt [3];
	logic        [POS_W-1:0]          cpos [3];
	logic        [2:0]                in_axis;
	logic                             probe_s1;
	logic        [CW-1:0]             cx_s1, cy_s1, cz_s1;

	// sign-extend the origins
	assign org_ext[0] = {{(POS_W-VEC_W){origin_x[VEC_W-1]}}, origin_x};
	assign org_ext[1] = {{(POS_W-VEC_W){origin_y[VEC_W-1]}}, origin_y};
	assign org_ext[2] = {{(POS_W-VEC_W){origin_z[VEC_W-1]}}, origin_z};

	// next position and its cell per axis
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			nxt[a]  = pos_q[a] + {{(POS_W-VEC_W){dir_q[a][VEC_W-1]}}, dir_q[a]};
			cpos[a] = $unsigned(nxt[a]) >> SHIFT;
		end
		in_axis[0] = !nxt[0][POS_W-1] && (cpos[0] < LIM_X);
		in_axis[1] = !nxt[1][POS_W-1] && (cpos[1] < LIM_Y);
		in_axis[2] = !nxt[2][POS_W-1] && (cpos[2] < LIM_Z);
	end

	// store address: width, then depth, then height
	assign rd_addr = {cpos[0][XW-1:0], cpos[2][ZW-1:0], cpos[1][YW-1:0]};

	// position, direction and step registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			pos_q[0] <= -(org_ext[0] <<< 1);
			pos_q[1] <= -(org_ext[1] <<< 1);
			pos_q[2] <= -(org_ext[2] <<< 1);
			dir_q[0] <= dir_x;
			dir_q[1] <= dir_y;
			dir_q[2] <= dir_z;
		end else if (ctl.step) begin
			for (int a = 0; a < 3; a++)
				pos_q[a] <= nxt[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (ctl.load) begin
			left_q <= max_steps;
		end else if (ctl.step) begin
			left_q <= left_q - 1'b1;
		end
	end

	// probe stage, lines up with the registered store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			probe_s1 <= 1'b0;
		else
			probe_s1 <= ctl.step && (&in_axis);
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			cx_s1 <= cpos[0][CW-1:0];
			cy_s1 <= cpos[1][CW-1:0];
			cz_s1 <= cpos[2][CW-1:0];
		end
	end

	assign stat.steps_zero = (left_q == '0);
	assign stat.probe_s1   = probe_s1;
	assign stat.cx_s1      = cx_s1;
	assign stat.cy_s1      = cy_s1;
	assign stat.cz_s1      = cz_s1;

endmodule

`default_nettype wire

### rtl/voxel_ray_march_core.sv
// ---------------------------------------------------------------------------
// voxel_ray_march_core
// Voxel grid of cell ids with a fixed half-step ray march.
//
//   channel  | handshake          | words
//   ---------+--------------------+--------------------------------------
//   command  | start / busy       | operation, cell_*, origin_*, dir_*,
//            |                    | max_steps
//   result   | done (one cycle)   | hit, block_id, hit_x, hit_height,
//            |                    | hit_depth
//
// After reset the voxel store is swept to zero, one entry a cycle, while busy
// is high. A write's result word follows in the cycle after it is accepted.
// A ray issues one store read per half step and checks its data in the next
// cycle; it ends after max_steps half steps, or early on a hit. The receiver
// cannot stall; each result word is shown once with done.
// ---------------------------------------------------------------------------
`default_nettype none

module voxel_ray_march_core #(
	parameter int GRID_WIDTH     = vrm_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT    = vrm_pkg::GRID_HEIGHT_DEF,
	parameter int GRID_DEPTH     = vrm_pkg::GRID_DEPTH_DEF,
	parameter int CELL_SIZE_LOG2 = vrm_pkg::CELL_SIZE_LOG2_DEF,
	parameter int ID_BITS        = vrm_pkg::ID_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              operation,
	input  wire logic        [vrm_pkg::COORD_W-1:0] cell_x,
	input  wire logic        [vrm_pkg::COORD_W-1:0] cell_height,
	input  wire logic        [vrm_pkg::COORD_W-1:0] cell_depth,
	input  wire logic        [vrm_pkg::ID_W-1:0]    cell_value,
	input  wire logic signed [vrm_pkg::VEC_W-1:0]   origin_x,
	input  wire logic signed [vrm_pkg::VEC_W-1:0]   origin_y,
	input  wire logic signed [vrm_pkg::VEC_W-1:0]   origin_z,
	input  wire logic signed [vrm_pkg::VEC_W-1:0]   dir_x,
	input  wire logic signed [vrm_pkg::VEC_W-1:0]   dir_y,
	input  wire logic signed [vrm_pkg::VEC_W-1:0]   dir_z,
	input  wire logic        [vrm_pkg::STEP_W-1:0]  max_steps,
	output logic                                   done,
	output logic                                   hit,
	output logic             [vrm_pkg::ID_W-1:0]    block_id,
	output logic             [vrm_pkg::COORD_W-1:0] hit_x,
	output logic             [vrm_pkg::COORD_W-1:0] hit_height,
	output logic             [vrm_pkg::COORD_W-1:0] hit_depth
);

	localparam int XW     = $clog2(GRID_WIDTH);
	localparam int YW     = $clog2(GRID_HEIGHT);
	localparam int ZW     = $clog2(GRID_DEPTH);
	localparam int ADDR_W = XW + YW + ZW;
	localparam int GW     = 9;  // holds grid sizes up to 511
	localparam int CW     = vrm_pkg::COORD_W;

	vrm_pkg::state_t      state_q, state_d;
	vrm_pkg::march_ctl_t  ctl;
	vrm_pkg::march_stat_t stat;

	logic [ADDR_W-1:0]  rd_addr;
	logic [ID_BITS-1:0] rd_data;
	logic               clr_done;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [GW-1:0]      wx, wy, wz;
	logic               w_in_grid;
	logic               accept, acc_write;
	logic               solid, finish;

	logic               done_q, hit_q;
	logic [ID_BITS-1:0] id_q;
	logic [CW-1:0]      hx_q, hy_q, hz_q;

	// write target, checked against the grid
	assign wx        = GW'(cell_x);
	assign wy        = GW'(cell_height);
	assign wz        = GW'(cell_depth);
	assign w_in_grid = (wx < GW'(GRID_WIDTH)) && (wy < GW'(GRID_HEIGHT))
	                   && (wz < GW'(GRID_DEPTH));
	assign wr_addr   = {wx[XW-1:0], wz[ZW-1:0], wy[YW-1:0]};

	// probed id is solid unless 0 or 1
	assign solid  = stat.probe_s1 && (|rd_data[ID_BITS-1:1]);
	assign finish = (state_q == vrm_pkg::ST_MARCH) && (solid || stat.steps_zero);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vrm_pkg::ST_CLEAR: begin
				if (clr_done)
					state_d = vrm_pkg::ST_IDLE;
			end
			vrm_pkg::ST_IDLE: begin
				if (start && (operation == vrm_pkg::OP_RAY))
					state_d = vrm_pkg::ST_MARCH;
			end
			vrm_pkg::ST_MARCH: begin
				if (finish)
					state_d = vrm_pkg::ST_IDLE;
			end
			default: state_d = vrm_pkg::ST_CLEAR;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		busy      = (state_q != vrm_pkg::ST_IDLE);
		accept    = start && (state_q == vrm_pkg::ST_IDLE);
		acc_write = accept && (operation == vrm_pkg::OP_WRITE);
		wr_en     = acc_write && w_in_grid;
		ctl.load  = accept && (operation == vrm_pkg::OP_RAY);
		ctl.step  = (state_q == vrm_pkg::ST_MARCH) && !finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= vrm_pkg::ST_CLEAR;
		else
			state_q <= state_d;
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			hit_q  <= 1'b0;
			id_q   <= '0;
			hx_q   <= '0;
			hy_q   <= '0;
			hz_q   <= '0;
		end else begin
			done_q <= acc_write || finish;
			if (finish && solid) begin
				hit_q <= 1'b1;
				id_q  <= rd_data;
				hx_q  <= stat.cx_s1;
				hy_q  <= stat.cy_s1;
				hz_q  <= stat.cz_s1;
			end else begin
				hit_q <= 1'b0;
				id_q  <= '0;
				hx_q  <= '0;
				hy_q  <= '0;
				hz_q  <= '0;
			end
		end
	end

	assign done       = done_q;
	assign hit        = hit_q;
	assign block_id   = vrm_pkg::ID_W'(id_q);
	assign hit_x      = hx_q;
	assign hit_height = hy_q;
	assign hit_depth  = hz_q;

	vrm_march #(
		.GRID_WIDTH     (GRID_WIDTH),
		.GRID_HEIGHT    (GRID_HEIGHT),
		.GRID_DEPTH     (GRID_DEPTH),
		.CELL_SIZE_LOG2 (CELL_SIZE_LOG2),
		.XW             (XW),
		.YW             (YW),
		.ZW             (ZW)
	) u_march (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.origin_x  (origin_x),
		.origin_y  (origin_y),
		.origin_z  (origin_z),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.dir_z     (dir_z),
		.max_steps (max_steps),
		.rd_addr   (rd_addr),
		.stat      (stat)
	);

	vrm_store #(
		.ADDR_W  (ADDR_W),
		.ID_BITS (ID_BITS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (cell_value[ID_BITS-1:0]),
		.rd_en    (ctl.step),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.clr_done (clr_done)
	);

endmodule

`default_nettype wire

### bench/voxel_ray_march_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// voxel_ray_march_core_test
// Self-checking bench for the voxel ray march core.
//
// A short table of directed words covers the extremes of the fields, both
// operations, ids 0 and 1, zero steps, and rays that start below zero or
// beyond the grid. A few hundred random words follow: most writes are packed
// into a small corner of the grid and most rays are aimed into it, so that
// the march really finds solid cells. The rest are rays with any field values.
// Each accepted word is run through a local model of the grid and the march.
// Result words are checked in order, field by field. The sender idles at a
// rate set for each phase, and it pauses between phases until no result is
// outstanding.
// ---------------------------------------------------------------------------

module voxel_ray_march_core_test;

	localparam int COORD_W      = vrm_pkg::COORD_W;
	localparam int ID_W         = vrm_pkg::ID_W;
	localparam int VEC_W        = vrm_pkg::VEC_W;
	localparam int STEP_W       = vrm_pkg::STEP_W;
	localparam int CELL_COUNT   = vrm_pkg::GRID_WIDTH_DEF * vrm_pkg::GRID_HEIGHT_DEF
	                              * vrm_pkg::GRID_DEPTH_DEF;
	localparam int CELL_SHIFT   = vrm_pkg::FRAC_BITS + vrm_pkg::CELL_SIZE_LOG2_DEF;
	localparam int NUM_DIRECTED = 22;
	localparam int NUM_PHASES   = 4;
	localparam int PHASE_WORDS  = 175;
	localparam int STALL_LIMIT  = 100000;  // covers the store sweep after reset
	localparam int DRAIN_CYCLES = 300;     // longest ray plus margin

	// one command word
	typedef struct packed {
		logic                      op;
		logic [COORD_W-1:0]        cx;
		logic [COORD_W-1:0]        cy;
		logic [COORD_W-1:0]        cz;
		logic [ID_W-1:0]           value;
		logic signed [VEC_W-1:0]   ox;
		logic signed [VEC_W-1:0]   oy;
		logic signed [VEC_W-1:0]   oz;
		logic signed [VEC_W-1:0]   dx;
		logic signed [VEC_W-1:0]   dy;
		logic signed [VEC_W-1:0]   dz;
		logic [STEP_W-1:0]         steps;
	} cmd_word_t;

	localparam int CMD_W = $bits(cmd_word_t);

	// one result word
	typedef struct packed {
		logic               hit;
		logic [ID_W-1:0]    block_id;
		logic [COORD_W-1:0] hx;
		logic [COORD_W-1:0] hy;
		logic [COORD_W-1:0] hz;
	} march_result_t;

	// directed row: the word, and an expected result where it is plain to see
	typedef struct packed {
		cmd_word_t     cmd;
		logic          typed;
		march_result_t want;
	} directed_row_t;

	localparam march_result_t NO_HIT = '0;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic                       operation;
	logic [COORD_W-1:0]         cell_x;
	logic [COORD_W-1:0]         cell_height;
	logic [COORD_W-1:0]         cell_depth;
	logic [ID_W-1:0]            cell_value;
	logic signed [VEC_W-1:0]    origin_x;
	logic signed [VEC_W-1:0]    origin_y;
	logic signed [VEC_W-1:0]    origin_z;
	logic signed [VEC_W-1:0]    dir_x;
	logic signed [VEC_W-1:0]    dir_y;
	logic signed [VEC_W-1:0]    dir_z;
	logic [STEP_W-1:0]          max_steps;
	logic                       done;
	logic                       hit;
	logic [ID_W-1:0]            block_id;
	logic [COORD_W-1:0]         hit_x;
	logic [COORD_W-1:0]         hit_height;
	logic [COORD_W-1:0]         hit_depth;

	// local copy of the grid, indexed {x, depth, height}
	logic [ID_W-1:0]            grid_ids [0:CELL_COUNT-1];
	march_result_t              awaited_results [$];
	directed_row_t              plan [0:NUM_DIRECTED-1];

	int failures;
	int writes_sent;
	int rays_sent;
	int hits_seen;
	int stall_cycles;

	voxel_ray_march_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.cell_x      (cell_x),
		.cell_height (cell_height),
		.cell_depth  (cell_depth),
		.cell_value  (cell_value),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.origin_z    (origin_z),
		.dir_x       (dir_x),
		.dir_y       (dir_y),
		.dir_z       (dir_z),
		.max_steps   (max_steps),
		.done        (done),
		.hit         (hit),
		.block_id    (block_id),
		.hit_x       (hit_x),
		.hit_height  (hit_height),
		.hit_depth   (hit_depth)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// word builders for the directed table
	function automatic cmd_word_t write_cmd(int x, int y, int z, int id);
		cmd_word_t w;
		w       = '0;
		w.op    = vrm_pkg::OP_WRITE;
		w.cx    = COORD_W'(x);
		w.cy    = COORD_W'(y);
		w.cz    = COORD_W'(z);
		w.value = ID_W'(id);
		return w;
	endfunction

	function automatic cmd_word_t ray_cmd(int ox, int oy, int oz, int dx, int dy, int dz,
			int n);
		cmd_word_t w;
		w       = '0;
		w.op    = vrm_pkg::OP_RAY;
		w.ox    = VEC_W'(ox);
		w.oy    = VEC_W'(oy);
		w.oz    = VEC_W'(oz);
		w.dx    = VEC_W'(dx);
		w.dy    = VEC_W'(dy);
		w.dz    = VEC_W'(dz);
		w.steps = STEP_W'(n);
		return w;
	endfunction

	function automatic march_result_t solid_at(int id, int x, int y, int z);
		march_result_t r;
		r.hit      = 1'b1;
		r.block_id = ID_W'(id);
		r.hx       = COORD_W'(x);
		r.hy       = COORD_W'(y);
		r.hz       = COORD_W'(z);
		return r;
	endfunction

	// grid update for writes, half-step march for rays
	function automatic march_result_t trace_ray_word(cmd_word_t w);
		march_result_t r;
		int            px, py, pz;
		int            gx, gy, gz;
		logic [ID_W-1:0] id;
		r = NO_HIT;
		if (w.op == vrm_pkg::OP_WRITE) begin
			grid_ids[{w.cx, w.cz, w.cy}] = w.value;
			return r;
		end
		// position in 1/512 units starts at minus twice the origin
		px = -2 * int'($signed(w.ox));
		py = -2 * int'($signed(w.oy));
		pz = -2 * int'($signed(w.oz));
		for (int k = 0; k < int'(w.steps); k++) begin
			px += int'($signed(w.dx));
			py += int'($signed(w.dy));
			pz += int'($signed(w.dz));
			// below zero or past the grid reads as empty
			if (px < 0 || py < 0 || pz < 0)
				continue;
			gx = px >>> CELL_SHIFT;
			gy = py >>> CELL_SHIFT;
			gz = pz >>> CELL_SHIFT;
			if (gx >= vrm_pkg::GRID_WIDTH_DEF || gy >= vrm_pkg::GRID_HEIGHT_DEF
			    || gz >= vrm_pkg::GRID_DEPTH_DEF)
				continue;
			id = grid_ids[{gx[COORD_W-1:0], gz[COORD_W-1:0], gy[COORD_W-1:0]}];
			if (id > 1)
				return solid_at(int'(id), gx, gy, gz);
		end
		return r;
	endfunction

	// random word: writes clustered in a corner, rays mostly aimed at it
	function automatic cmd_word_t random_cmd();
		cmd_word_t w;
		int        kind;
		w    = CMD_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
		kind = $urandom_range(99);
		if (kind < 35) begin
			w.op = vrm_pkg::OP_WRITE;
			if ($urandom_range(9) < 7) begin
				w.cx = COORD_W'($urandom_range(7));
				w.cy = COORD_W'($urandom_range(7));
				w.cz = COORD_W'($urandom_range(7));
			end
			case ($urandom_range(4))
				0: w.value = '0;
				1: w.value = ID_W'(1);
				2: w.value = ID_W'(2);
				default: ;
			endcase
		end else if (kind < 85) begin
			w.op    = vrm_pkg::OP_RAY;
			w.ox    = VEC_W'(-int'($urandom_range(8192)));
			w.oy    = VEC_W'(-int'($urandom_range(8192)));
			w.oz    = VEC_W'(-int'($urandom_range(8192)));
			w.dx    = VEC_W'(int'($urandom_range(2048)) - 1024);
			w.dy    = VEC_W'(int'($urandom_range(2048)) - 1024);
			w.dz    = VEC_W'(int'($urandom_range(2048)) - 1024);
			w.steps = ($urandom_range(9) == 0) ? STEP_W'(255) : STEP_W'($urandom_range(48));
		end else begin
			w.op = vrm_pkg::OP_RAY;
		end
		return w;
	endfunction

	// present one word and hold it until taken
	task automatic issue_word(input cmd_word_t w, input logic typed,
			input march_result_t want);
		march_result_t model;
		operation   <= w.op;
		cell_x      <= w.cx;
		cell_height <= w.cy;
		cell_depth  <= w.cz;
		cell_value  <= w.value;
		origin_x    <= w.ox;
		origin_y    <= w.oy;
		origin_z    <= w.oz;
		dir_x       <= w.dx;
		dir_y       <= w.dy;
		dir_z       <= w.dz;
		max_steps   <= w.steps;
		start       <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		model = trace_ray_word(w);
		awaited_results.insert(awaited_results.size(), typed ? want : model);
		if (w.op == vrm_pkg::OP_WRITE)
			writes_sent++;
		else
			rays_sent++;
	endtask

	// hold start low while the sender idles
	task automatic sender_gap(input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			failures++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		march_result_t want;
		if (arst_n && done === 1'b1) begin
			if (hit === 1'b1)
				hits_seen++;
			if (awaited_results.size() == 0) begin
				$error("result word with none outstanding");
				failures++;
			end else begin
				want = awaited_results.pop_front();
				compare_field("hit", int'(want.hit), int'(hit));
				compare_field("block_id", int'(want.block_id), int'(block_id));
				compare_field("hit_x", int'(want.hx), int'(hit_x));
				compare_field("hit_height", int'(want.hy), int'(hit_height));
				compare_field("hit_depth", int'(want.hz), int'(hit_depth));
			end
		end
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if ((start && !busy) || done === 1'b1)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("voxel_ray_march_core regression: fail");
			$finish;
		end
	end

	initial begin
		int idle_pct [NUM_PHASES];
		failures     = 0;
		writes_sent  = 0;
		rays_sent    = 0;
		hits_seen    = 0;
		stall_cycles = 0;
		idle_pct     = '{0, 81, 0, 36};
		foreach (grid_ids[i])
			grid_ids[i] = '0;

		arst_n      = 1'b0;
		start       = 1'b0;
		operation   = vrm_pkg::OP_WRITE;
		cell_x      = '0;
		cell_height = '0;
		cell_depth  = '0;
		cell_value  = '0;
		origin_x    = '0;
		origin_y    = '0;
		origin_z    = '0;
		dir_x       = '0;
		dir_y       = '0;
		dir_z       = '0;
		max_steps   = '0;

		// origin -128 puts a ray at half a world unit; dir 512 is one unit a step
		plan = '{
			// fresh grid is all empty
			'{ray_cmd(-128, -128, -128, 256, 256, 256, 255), 1'b1, NO_HIT},
			// zero steps never reads the grid
			'{ray_cmd(0, 0, 0, 256, 256, 256, 0), 1'b1, NO_HIT},
			'{write_cmd(31, 31, 31, 'hFFFF), 1'b1, NO_HIT},
			'{write_cmd(0, 0, 0, 'h1234), 1'b1, NO_HIT},
			'{write_cmd(1, 0, 0, 1), 1'b1, NO_HIT},
			'{write_cmd(2, 0, 0, 0), 1'b1, NO_HIT},
			'{write_cmd(3, 0, 0, 5), 1'b1, NO_HIT},
			'{write_cmd(0, 31, 0, 2), 1'b1, NO_HIT},
			'{write_cmd(0, 0, 31, 'h8000), 1'b1, NO_HIT},
			'{ray_cmd(0, 0, 0, 256, 256, 256, 4), 1'b0, NO_HIT},
			// passes ids 1 and 0 before the solid cell
			'{ray_cmd(-1024, -64, -64, 512, 0, 0, 20), 1'b0, NO_HIT},
			// starts below zero and walks in
			'{ray_cmd(2048, -64, -64, 1024, 0, 0, 10), 1'b0, NO_HIT},
			// starts past the far face and walks back
			'{ray_cmd(-32768, -64, -64, -32768, 0, 0, 4), 1'b0, NO_HIT},
			'{ray_cmd(32767, 32767, 32767, 32767, 32767, 32767, 255), 1'b0, NO_HIT},
			// far corner and the two other extreme cells
			'{ray_cmd(-32000, -32000, -32000, 0, 0, 0, 1), 1'b1,
				solid_at('hFFFF, 31, 31, 31)},
			'{ray_cmd(-128, -32000, -128, 0, 0, 0, 3), 1'b1, solid_at(2, 0, 31, 0)},
			'{ray_cmd(-128, -128, -32000, 0, 0, 0, 1), 1'b1, solid_at('h8000, 0, 0, 31)},
			'{write_cmd(31, 31, 31, 0), 1'b1, NO_HIT},
			'{ray_cmd(-32000, -32000, -32000, 0, 0, 0, 1), 1'b0, NO_HIT},
			// standing still for the full count
			'{ray_cmd(-2560, -2560, -2560, 0, 0, 0, 255), 1'b0, NO_HIT},
			'{ray_cmd(-32768, -32768, -32768, -32768, -32768, -32768, 255), 1'b0, NO_HIT},
			// parked in an id 1 cell
			'{ray_cmd(-1280, -64, -64, 0, 0, 0, 8), 1'b0, NO_HIT}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (plan[i])
			issue_word(plan[i].cmd, plan[i].typed, plan[i].want);
		drain_results();

		// random phases at several idle rates, settling between phases
		for (int p = 0; p < NUM_PHASES; p++) begin
			for (int n = 0; n < PHASE_WORDS; n++) begin
				sender_gap(idle_pct[p]);
				issue_word(random_cmd(), 1'b0, NO_HIT);
			end
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Drove %0d writes and %0d rays, %0d directed; %0d results were hits.",
			writes_sent, rays_sent, NUM_DIRECTED, hits_seen);
		$display("Sender idle rates per phase: 0, 81, 0 and 36 in a hundred.");
		if (failures == 0 && awaited_results.size() == 0)
			$display("voxel_ray_march_core regression: pass");
		else
			$display("voxel_ray_march_core regression: fail");
		$finish;
	end

endmodule
